/* rtl/abs_pkg.sv */
// alarm buzzer sequencer package: beep phase codes, register indexes and reset values
// used by the top level alarm_buzzer_sequencer; no dependencies
package abs_pkg;

  // entry double beep phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BEEP1 = 3'd1,
    PH_GAP   = 3'd2,
    PH_BEEP2 = 3'd3,
    PH_DONE  = 3'd4
  } beep_phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HOLD_TIME   = 3'd0,
    REG_MUTE_TIME   = 3'd1,
    REG_BEEP_TIME   = 3'd2,
    REG_GAP_TIME    = 3'd3,
    REG_FIRST_TONE  = 3'd4,
    REG_HALF_PERIOD = 3'd5
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NowW     = 32;
  localparam int unsigned InDataW  = 40;  // now_ms, button, condition, mute value, padding
  localparam int unsigned OutDataW = 8;   // four result fields, padding

  localparam logic [15:0] HoldTimeRst   = 16'd2000;
  localparam logic [31:0] MuteTimeRst   = 32'd300000;
  localparam logic [15:0] BeepTimeRst   = 16'd100;
  localparam logic [15:0] GapTimeRst    = 16'd100;
  localparam logic [15:0] FirstToneRst  = 16'd200;
  localparam logic [15:0] HalfPeriodRst = 16'd500;

  // result fields registered at the output
  typedef struct packed {
    logic       buzzer_on;
    logic       buzzer_enabled;
    logic       alarm_active;
    logic [2:0] beep_phase;
  } result_t;

endpackage

/* rtl/alarm_buzzer_sequencer.sv */
// alarm buzzer sequencer top level: input register, single-pass state update, result register
// depends on abs_pkg

// Alarm buzzer controller. Each request is an update tick (tuser 0) or a remote mute/unmute
// request (tuser 1), both stamped with a millisecond time; time differences wrap modulo
// 2^TIME_BITS. A request is held in an input register, the whole state update is one pass
// of compare-and-select logic, and the result lands in an output register; the throughput
// is one request per cycle while the result side keeps taking data. Configuration writes are
// taken at once (cfg_ready_o is always high) and must only be issued while no request is in
// flight; a write to an index beyond the six registers is ignored.
module alarm_buzzer_sequencer
  import abs_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now_ms[31:0], button_pressed[32], alarm_condition[33], mute_value[34], zeros[39:35]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func[0]: 0 update tick, 1 mute request
  input  logic                s_axis_tuser,
  // result channel
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // buzzer_on[0], buzzer_enabled[1], alarm_active[2], beep_phase_out[5:3], zeros[7:6]
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  // configuration registers
  logic [15:0] hold_time_q, beep_time_q, gap_time_q, first_tone_q, half_period_q;
  logic [31:0] mute_time_q;

  // input register
  logic          in_valid_q, in_valid_d;
  logic          func_q;
  logic [TW-1:0] now_q;
  logic          pressed_q, cond_q, mute_val_q;

  // controller state
  logic          enabled_q, enabled_d;
  logic          active_q, active_d;
  logic [TW-1:0] mute_start_q, mute_start_d;
  logic          last_btn_q, last_btn_d;
  logic          hold_done_q, hold_done_d;
  logic [TW-1:0] btn_time_q, btn_time_d;
  logic [2:0]    phase_q, phase_d;
  logic [TW-1:0] beep_mark_q, beep_mark_d;
  logic [TW-1:0] alarm_start_q, alarm_start_d;
  logic [TW-1:0] toggle_mark_q, toggle_mark_d;
  logic          tone_q, tone_d;
  logic          buzz_q, buzz_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t res_q;

  logic s_acc, advance, work;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign work          = in_valid_q && advance;
  assign in_valid_d    = s_acc || (in_valid_q && !advance);
  assign out_valid_d   = work || (out_valid_q && !m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 6){1'b0}}, res_q.beep_phase, res_q.alarm_active,
                          res_q.buzzer_enabled, res_q.buzzer_on};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_time_q   <= HoldTimeRst;
      mute_time_q   <= MuteTimeRst;
      beep_time_q   <= BeepTimeRst;
      gap_time_q    <= GapTimeRst;
      first_tone_q  <= FirstToneRst;
      half_period_q <= HalfPeriodRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HOLD_TIME:   hold_time_q   <= cfg_data_i[15:0];
        REG_MUTE_TIME:   mute_time_q   <= cfg_data_i;
        REG_BEEP_TIME:   beep_time_q   <= cfg_data_i[15:0];
        REG_GAP_TIME:    gap_time_q    <= cfg_data_i[15:0];
        REG_FIRST_TONE:  first_tone_q  <= cfg_data_i[15:0];
        REG_HALF_PERIOD: half_period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // request payload needs no reset
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q     <= s_axis_tuser;
      now_q      <= TW'(s_axis_tdata[NowW-1:0]);
      pressed_q  <= s_axis_tdata[NowW];
      cond_q     <= s_axis_tdata[NowW+1];
      mute_val_q <= s_axis_tdata[NowW+2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (work) begin
      res_q.buzzer_on      <= buzz_d;
      res_q.buzzer_enabled <= enabled_d;
      res_q.alarm_active   <= active_d;
      res_q.beep_phase     <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      enabled_q     <= 1'b1;
      active_q      <= 1'b0;
      mute_start_q  <= '0;
      last_btn_q    <= 1'b1;
      hold_done_q   <= 1'b0;
      btn_time_q    <= '0;
      phase_q       <= PH_IDLE;
      beep_mark_q   <= '0;
      alarm_start_q <= '0;
      toggle_mark_q <= '0;
      tone_q        <= 1'b0;
      buzz_q        <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (work) begin
        enabled_q     <= enabled_d;
        active_q      <= active_d;
        mute_start_q  <= mute_start_d;
        last_btn_q    <= last_btn_d;
        hold_done_q   <= hold_done_d;
        btn_time_q    <= btn_time_d;
        phase_q       <= phase_d;
        beep_mark_q   <= beep_mark_d;
        alarm_start_q <= alarm_start_d;
        toggle_mark_q <= toggle_mark_d;
        tone_q        <= tone_d;
        buzz_q        <= buzz_d;
      end
    end
  end

  // one pass over the request, in the order the controller evaluates it
  always_comb begin
    logic [TW-1:0] el_btn, el_mute, el_beep, el_alarm, el_toggle;
    logic          seq_busy;
    enabled_d     = enabled_q;
    active_d      = active_q;
    mute_start_d  = mute_start_q;
    last_btn_d    = last_btn_q;
    hold_done_d   = hold_done_q;
    btn_time_d    = btn_time_q;
    phase_d       = phase_q;
    beep_mark_d   = beep_mark_q;
    alarm_start_d = alarm_start_q;
    toggle_mark_d = toggle_mark_q;
    tone_d        = tone_q;
    buzz_d        = buzz_q;
    seq_busy      = 1'b0;
    el_btn        = '0;
    el_mute       = '0;
    el_beep       = '0;
    el_alarm      = '0;
    el_toggle     = '0;

    if (func_q) begin
      if (mute_val_q) begin
        enabled_d    = 1'b0;
        buzz_d       = 1'b0;
        active_d     = 1'b0;
        mute_start_d = now_q;
      end else begin
        enabled_d = 1'b1;
        // a running double beep is left alone
        if (phase_q == PH_IDLE) begin
          phase_d     = PH_BEEP1;
          beep_mark_d = now_q;
          buzz_d      = 1'b1;
        end
      end
    end else begin
      if (pressed_q != last_btn_q) begin
        btn_time_d  = now_q;
        last_btn_d  = pressed_q;
        hold_done_d = 1'b0;
      end
      el_btn = now_q - btn_time_d;
      if (pressed_q && !hold_done_d && CW'(el_btn) >= CW'(hold_time_q)) begin
        hold_done_d = 1'b1;
        if (enabled_q) begin
          enabled_d    = 1'b0;
          buzz_d       = 1'b0;
          active_d     = 1'b0;
          mute_start_d = now_q;
        end else begin
          enabled_d = 1'b1;
          if (phase_q == PH_IDLE) begin
            phase_d     = PH_BEEP1;
            beep_mark_d = now_q;
            buzz_d      = 1'b1;
          end
        end
      end
      el_mute = now_q - mute_start_d;
      if (!enabled_d && CW'(el_mute) > CW'(mute_time_q)) begin
        enabled_d = 1'b1;
      end

      if (!enabled_d) begin
        buzz_d   = 1'b0;
        active_d = 1'b0;
        phase_d  = PH_IDLE;
      end else begin
        el_beep = now_q - beep_mark_d;
        case (phase_d)
          PH_BEEP1: begin
            seq_busy = 1'b1;
            if (CW'(el_beep) >= CW'(beep_time_q)) begin
              buzz_d = 1'b0; phase_d = PH_GAP; beep_mark_d = now_q;
            end
          end
          PH_GAP: begin
            seq_busy = 1'b1;
            if (CW'(el_beep) >= CW'(gap_time_q)) begin
              buzz_d = 1'b1; phase_d = PH_BEEP2; beep_mark_d = now_q;
            end
          end
          PH_BEEP2: begin
            seq_busy = 1'b1;
            if (CW'(el_beep) >= CW'(beep_time_q)) begin
              buzz_d = 1'b0; phase_d = PH_DONE; beep_mark_d = now_q;
            end
          end
          PH_DONE: begin
            phase_d = PH_IDLE;
            if (active_d) begin
              alarm_start_d = now_q;
              toggle_mark_d = now_q;
              tone_d        = 1'b1;
              buzz_d        = 1'b1;
            end else begin
              buzz_d = 1'b0;
            end
          end
          default: ;
        endcase

        if (!seq_busy) begin
          el_alarm  = now_q - alarm_start_d;
          el_toggle = now_q - toggle_mark_d;
          if (cond_q) begin
            if (!active_d && phase_d == PH_IDLE) begin
              // condition rising: entry double beep first
              active_d    = 1'b1;
              phase_d     = PH_BEEP1;
              beep_mark_d = now_q;
              buzz_d      = 1'b1;
            end else if (CW'(el_alarm) < CW'(first_tone_q)) begin
              if (!tone_d) begin
                tone_d = 1'b1;
                buzz_d = 1'b1;
              end
            end else if (CW'(el_toggle) >= CW'(half_period_q)) begin
              // advance the mark by the period, not to now, so the rhythm does not drift
              toggle_mark_d = toggle_mark_d + TW'(half_period_q);
              tone_d        = !tone_d;
              buzz_d        = tone_d;
            end
          end else begin
            buzz_d   = 1'b0;
            active_d = 1'b0;
            phase_d  = PH_IDLE;
          end
        end
      end
    end
  end

  a_muted_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.buzzer_enabled |-> !res_q.buzzer_on && !res_q.alarm_active)
    else $error("muted result shows buzzer or alarm active");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE || phase_q == PH_BEEP1 || phase_q == PH_GAP ||
    phase_q == PH_BEEP2 || phase_q == PH_DONE)
    else $error("beep phase outside its sequence");

  a_held_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(now_q))
    else $error("stalled request lost from the input register");

  a_beep_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work && func_q == 1'b0 && phase_d != PH_IDLE |-> enabled_d)
    else $error("beep sequence running while muted after a tick");

endmodule

/* verif/alarm_buzzer_sequencer_tb.sv */
// testbench for alarm_buzzer_sequencer: directed and random tick/mute traffic checked
// against a cycle-free behavioural copy of the buzzer controller; depends on abs_pkg
`timescale 1ns / 100ps

module alarm_buzzer_sequencer_tb;
  import abs_pkg::*;

  localparam int HalfClkNs      = 2;
  localparam int ResetCycles    = 5;
  localparam int SettleCycles   = 4;
  localparam int QuietLimit     = 3000;
  localparam int TotalRequests  = 1150;
  localparam int PrintLimit     = 100;

  localparam bit FuncTick    = 1'b0;
  localparam bit FuncMuteReq = 1'b1;
  localparam bit MuteOn      = 1'b1;
  localparam bit MuteOff     = 1'b0;

  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;

  localparam int RxFree   = 0;
  localparam int RxPatchy = 1;
  localparam int RxSparse = 2;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  alarm_buzzer_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #HalfClkNs clk_i = ~clk_i;

  // settings as the block should hold them
  logic [15:0] hold_t  = HoldTimeRst;
  logic [31:0] mute_t  = MuteTimeRst;
  logic [15:0] beep_t  = BeepTimeRst;
  logic [15:0] gap_t   = GapTimeRst;
  logic [15:0] first_t = FirstToneRst;
  logic [15:0] half_t  = HalfPeriodRst;

  // controller state; the button counts as pressed out of reset
  logic        en_q        = 1'b1;
  logic        act_q       = 1'b0;
  logic        last_btn_q  = 1'b1;
  logic        hold_done_q = 1'b0;
  logic        tone_q      = 1'b0;
  logic        buzz_q      = 1'b0;
  logic [31:0] mute_start_q  = '0;
  logic [31:0] btn_change_q  = '0;
  logic [31:0] beep_mark_q   = '0;
  logic [31:0] alarm_start_q = '0;
  logic [31:0] toggle_mark_q = '0;
  beep_phase_e phase_q = PH_IDLE;

  result_t     buzz_expect_q[$];
  int unsigned fails       = 0;
  int unsigned results_in  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 1;
  int unsigned rx_left     = 0;
  int          rx_mode     = RxFree;
  logic [31:0] clock_ms    = '0;

  function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] mark);
    return now - mark;
  endfunction

  function automatic void go_silent(input logic [31:0] now);
    en_q = 1'b0;
    buzz_q = 1'b0;
    act_q = 1'b0;
    mute_start_q = now;
  endfunction

  function automatic void begin_double_beep(input logic [31:0] now);
    if (phase_q == PH_IDLE) begin
      phase_q = PH_BEEP1;
      beep_mark_q = now;
      buzz_q = 1'b1;
    end
  endfunction

  // advances the entry beep; high while the beep still owns the buzzer
  function automatic bit beeps_running(input logic [31:0] now);
    case (phase_q)
      PH_BEEP1: begin
        if (ms_since(now, beep_mark_q) >= beep_t) begin
          buzz_q = 1'b0;
          phase_q = PH_GAP;
          beep_mark_q = now;
        end
        return 1'b1;
      end
      PH_GAP: begin
        if (ms_since(now, beep_mark_q) >= gap_t) begin
          buzz_q = 1'b1;
          phase_q = PH_BEEP2;
          beep_mark_q = now;
        end
        return 1'b1;
      end
      PH_BEEP2: begin
        if (ms_since(now, beep_mark_q) >= beep_t) begin
          buzz_q = 1'b0;
          phase_q = PH_DONE;
          beep_mark_q = now;
        end
        return 1'b1;
      end
      PH_DONE: begin
        phase_q = PH_IDLE;
        if (act_q) begin
          alarm_start_q = now;
          toggle_mark_q = now;
          tone_q = 1'b1;
          buzz_q = 1'b1;
        end else begin
          buzz_q = 1'b0;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void tick_update(input logic [31:0] now, input bit pressed, input bit cond);
    if (pressed != last_btn_q) begin
      btn_change_q = now;
      last_btn_q = pressed;
      hold_done_q = 1'b0;
    end
    if (pressed && !hold_done_q && ms_since(now, btn_change_q) >= hold_t) begin
      hold_done_q = 1'b1;
      if (en_q) begin
        go_silent(now);
      end else begin
        en_q = 1'b1;
        begin_double_beep(now);
      end
    end
    if (!en_q && ms_since(now, mute_start_q) > mute_t) en_q = 1'b1;

    if (!en_q) begin
      buzz_q = 1'b0;
      act_q = 1'b0;
      phase_q = PH_IDLE;
      return;
    end
    if (phase_q != PH_IDLE && beeps_running(now)) return;

    if (cond) begin
      if (!act_q && phase_q == PH_IDLE) begin
        act_q = 1'b1;
        phase_q = PH_BEEP1;
        beep_mark_q = now;
        buzz_q = 1'b1;
        return;
      end
      if (ms_since(now, alarm_start_q) < first_t) begin
        if (!tone_q) begin
          tone_q = 1'b1;
          buzz_q = 1'b1;
        end
      end else if (ms_since(now, toggle_mark_q) >= half_t) begin
        // step the mark by a whole half period so late ticks do not drift
        toggle_mark_q = toggle_mark_q + half_t;
        tone_q = !tone_q;
        buzz_q = tone_q;
      end
    end else begin
      buzz_q = 1'b0;
      act_q = 1'b0;
      phase_q = PH_IDLE;
    end
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < PrintLimit) $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  // sends one request and records the state it should leave behind
  task automatic send_request(input bit func, input logic [31:0] now, input bit pressed,
                              input bit cond, input bit mute_val);
    result_t want;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {5'b0, mute_val, cond, pressed, now};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FuncMuteReq) begin
      if (mute_val == MuteOn) begin
        go_silent(now);
      end else begin
        en_q = 1'b1;
        begin_double_beep(now);
      end
    end else begin
      tick_update(now, pressed, cond);
    end
    want.buzzer_on      = buzz_q;
    want.buzzer_enabled = en_q;
    want.alarm_active   = act_q;
    want.beep_phase     = phase_q;
    buzz_expect_q.push_back(want);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_settled();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (buzz_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_HOLD_TIME:   hold_t  = value[15:0];
      REG_MUTE_TIME:   mute_t  = value;
      REG_BEEP_TIME:   beep_t  = value[15:0];
      REG_GAP_TIME:    gap_t   = value[15:0];
      REG_FIRST_TONE:  first_t = value[15:0];
      REG_HALF_PERIOD: half_t  = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] hold, input logic [31:0] mute,
                               input logic [15:0] beep, input logic [15:0] gap,
                               input logic [15:0] first, input logic [15:0] half);
    wait_settled();
    write_setting(REG_HOLD_TIME, {16'b0, hold});
    write_setting(REG_MUTE_TIME, mute);
    write_setting(REG_BEEP_TIME, {16'b0, beep});
    write_setting(REG_GAP_TIME, {16'b0, gap});
    write_setting(REG_FIRST_TONE, {16'b0, first});
    write_setting(REG_HALF_PERIOD, {16'b0, half});
  endtask

  function automatic logic [15:0] pick_span(input int unsigned top);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, top));
    endcase
  endfunction

  // reset settings: long hold mutes, unmute beeps, then an alarm runs its full rhythm
  task automatic test_default_sequence();
    int k;
    send_request(FuncTick, 32'd0, 1'b1, 1'b0, MuteOff);
    send_request(FuncTick, 32'd1999, 1'b1, 1'b0, MuteOn);
    send_request(FuncTick, 32'd2000, 1'b1, 1'b0, MuteOff);
    send_request(FuncMuteReq, 32'd2001, 1'b0, 1'b0, MuteOff);
    // unmute while the beep is running must not restart it
    send_request(FuncMuteReq, 32'd2050, 1'b1, 1'b1, MuteOff);
    send_request(FuncTick, 32'd2100, 1'b0, 1'b1, MuteOff);
    send_request(FuncTick, 32'd2101, 1'b0, 1'b1, MuteOff);
    // mute keeps the phase until the next tick
    send_request(FuncMuteReq, 32'd2150, 1'b0, 1'b1, MuteOn);
    send_request(FuncTick, 32'd2151, 1'b0, 1'b1, MuteOff);
    send_request(FuncMuteReq, 32'd2200, 1'b0, 1'b0, MuteOff);
    for (k = 1; k <= 11; k++) send_request(FuncTick, 32'd2200 + 32'(k * 200), 1'b0, 1'b1, MuteOff);
    send_request(FuncTick, 32'd4500, 1'b0, 1'b0, MuteOff);
    clock_ms = 32'd4500;
  endtask

  // all times zero: every compare but the strict mute timeout is met at once, the rhythm toggles every tick
  task automatic test_zero_times();
    int k;
    load_settings('0, '0, '0, '0, '0, '0);
    write_setting(SpareIdxLo, 32'hFFFF_FFFF);
    write_setting(SpareIdxHi, 32'hFFFF_FFFF);
    for (k = 0; k < 7; k++) send_request(FuncTick, clock_ms, 1'b0, 1'b1, MuteOff);
    send_request(FuncTick, clock_ms, 1'b1, 1'b1, MuteOff);
    send_request(FuncTick, clock_ms, 1'b1, 1'b1, MuteOff);
    send_request(FuncTick, clock_ms + 32'd1, 1'b0, 1'b1, MuteOff);
  endtask

  // all times at their top, stamps crossing the wrap of the millisecond counter
  task automatic test_max_times();
    load_settings(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(FuncTick, 32'hFFFF_FFFF, 1'b1, 1'b1, MuteOn);
    send_request(FuncTick, 32'h0000_FFFE, 1'b1, 1'b1, MuteOff);
    send_request(FuncTick, 32'h0001_0000, 1'b0, 1'b1, MuteOff);
    send_request(FuncMuteReq, 32'h8000_0000, 1'b1, 1'b0, MuteOn);
    send_request(FuncTick, 32'hFFFF_FFFF, 1'b0, 1'b0, MuteOff);
  endtask

  // mostly coherent alarm episodes with random content, some requests and stamp noise
  task automatic run_episode(input int unsigned count, input int unsigned step_top);
    bit cond;
    bit btn;
    int unsigned r;
    cond = ($urandom_range(0, 3) != 0);
    btn  = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      r = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, step_top);
      if (r < 5) begin
        send_request(FuncMuteReq, clock_ms, 1'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 7) begin
        clock_ms = $urandom();
        send_request(FuncTick, clock_ms, 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        if ($urandom_range(0, 15) == 0) btn = !btn;
        if ($urandom_range(0, 29) == 0) cond = !cond;
        send_request(FuncTick, clock_ms, btn, cond, 1'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned phase_no;
    int unsigned step_top;
    int unsigned stop_at;
    logic [31:0] mute;
    for (phase_no = 0; items_sent < TotalRequests; phase_no++) begin
      mute = ($urandom_range(0, 12) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 400);
      load_settings(pick_span(80), mute, pick_span(30), pick_span(30), pick_span(60),
                    pick_span(40));
      if (phase_no == 2) clock_ms = 32'hFFFF_F000;
      step_top = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 2000) : $urandom_range(1, 20);
      stop_at = items_sent + 140;
      while (items_sent < stop_at && items_sent < TotalRequests) begin
        run_episode($urandom_range(8, 40), step_top);
        // hold the sender back until the block has emptied
        if (phase_no == 1) wait_settled();
      end
    end
  endtask

  // receiver readiness: free running, patchy and sparse stretches
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RxFree, RxSparse);
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    case (rx_mode)
      RxFree:   m_axis_tready <= 1'b1;
      RxPatchy: m_axis_tready <= 1'($urandom);
      default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_in++;
      if (buzz_expect_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_in));
      end else begin
        want = buzz_expect_q.pop_front();
        if (m_axis_tdata[0] !== want.buzzer_on)
          report_mismatch($sformatf("result %0d buzzer_on %b, expected %b",
                                    results_in, m_axis_tdata[0], want.buzzer_on));
        if (m_axis_tdata[1] !== want.buzzer_enabled)
          report_mismatch($sformatf("result %0d buzzer_enabled %b, expected %b",
                                    results_in, m_axis_tdata[1], want.buzzer_enabled));
        if (m_axis_tdata[2] !== want.alarm_active)
          report_mismatch($sformatf("result %0d alarm_active %b, expected %b",
                                    results_in, m_axis_tdata[2], want.alarm_active));
        if (m_axis_tdata[5:3] !== want.beep_phase)
          report_mismatch($sformatf("result %0d beep_phase %0d, expected %0d",
                                    results_in, m_axis_tdata[5:3], want.beep_phase));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("alarm_buzzer_sequencer_tb failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FuncTick;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_HOLD_TIME;
    cfg_data_i    = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_sequence();
    test_zero_times();
    test_max_times();
    test_random_traffic();
    wait_settled();

    if (fails == 0) $display("alarm_buzzer_sequencer_tb passed");
    else $display("alarm_buzzer_sequencer_tb failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/abs_pkg.sv
rtl/alarm_buzzer_sequencer.sv
verif/alarm_buzzer_sequencer_tb.sv
